/* rtl/core/tpd_pkg.sv */
// Package for the trace packet decoder: beat types, packet kind codes and the
// combinational packet decode function. No dependencies.
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int HoldDepth = 18;
    localparam int HoldIdxW  = 5;

    localparam logic [4:0] KIND_UNKNOWN    = 5'd0;
    localparam logic [4:0] KIND_INCOMPLETE = 5'd1;
    localparam logic [4:0] KIND_ASYNC      = 5'd2;
    localparam logic [4:0] KIND_OVERFLOW   = 5'd3;
    localparam logic [4:0] KIND_TRACEINFO  = 5'd4;
    localparam logic [4:0] KIND_TIMESTAMP  = 5'd5;
    localparam logic [4:0] KIND_TRACEON    = 5'd6;
    localparam logic [4:0] KIND_CONTEXT    = 5'd7;
    localparam logic [4:0] KIND_EXCEPTION  = 5'd8;
    localparam logic [4:0] KIND_ADDRSHORT  = 5'd9;
    localparam logic [4:0] KIND_ADDRLONG   = 5'd10;
    localparam logic [4:0] KIND_ADDRLCTX   = 5'd11;
    localparam logic [4:0] KIND_ATOMF1     = 5'd12;
    localparam logic [4:0] KIND_ATOMF2     = 5'd13;
    localparam logic [4:0] KIND_ATOMF3     = 5'd14;
    localparam logic [4:0] KIND_ATOMF4     = 5'd15;
    localparam logic [4:0] KIND_ATOMF5     = 5'd16;
    localparam logic [4:0] KIND_ATOMF6     = 5'd17;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]  packet_kind;
        logic [4:0]  pkt_len;
        logic [23:0] atom_bits;
        logic [4:0]  atom_count;
        logic [63:0] address;
        logic        last_of_run;
    } t_out_beat;

    typedef logic [HoldDepth-1:0][7:0] t_hold;

    // Result of looking at the packet at the front of the store.
    typedef struct packed {
        logic        done;      // packet complete
        logic [4:0]  kind;
        logic [4:0]  size;
        logic [23:0] atoms;
        logic [4:0]  count;
        logic [63:0] addr;
        logic        upd_addr;  // address register takes addr
    } t_dec;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;      // append the input byte
        logic flush;     // emit incomplete and empty the store
        logic consume;   // stage the decoded packet and drop its bytes
        logic mark;      // set the last flag of the staged beat
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       done;
        logic       lead_done;  // packet complete when the next byte is appended
        logic [4:0] count;
    } t_stat;

    function automatic logic [2:0] ctx_extra4(input logic [7:0] info);
        ctx_extra4 = {2'b00, info[6]} + {2'b00, info[7]};
    endfunction

    function automatic logic [63:0] long_addr(input t_hold b);
        long_addr = {b[8], b[7], b[6], b[5], b[4], b[3], 16'h0000}
                  | {48'h0, b[2][6:0], b[1][6:0], 2'b00};
    endfunction

    function automatic t_dec decode(input t_hold b, input logic [4:0] n,
                                    input logic [63:0] areg);
        t_dec d;
        logic [7:0] h;
        logic [4:0] need;
        logic [4:0] e;
        logic [24:0] bits;
        logic        async_ok;
        logic [63:0] a;
        logic [2:0]  idx;
        d = '0;
        h = b[0];
        need = 5'd1;
        e = 5'd0;
        bits = '0;
        a = '0;
        idx = 3'd0;
        async_ok = 1'b1;
        for (int i = 0; i <= 10; i++) begin
            if (b[i] != 8'h00) async_ok = 1'b0;
        end
        if (b[11] != 8'h80) async_ok = 1'b0;
        d.size = 5'd1;
        d.kind = KIND_UNKNOWN;
        if (n == 5'd0) begin
            d.done = 1'b0;
        end else if (h == 8'h00) begin
            if (n >= 5'd2 && b[1] == 8'h05) begin
                d.done = 1'b1; d.kind = KIND_OVERFLOW; d.size = 5'd2;
            end else if (n >= 5'd12) begin
                d.done = 1'b1;
                if (async_ok) begin
                    d.kind = KIND_ASYNC; d.size = 5'd12;
                end
            end
        end else if (h == 8'h01) begin
            d.done = (n >= 5'd2); d.kind = KIND_TRACEINFO; d.size = 5'd2;
        end else if (h == 8'h02 || h == 8'h03) begin
            need = h[0] ? 5'd11 : 5'd8;
            d.done = (n >= need); d.kind = KIND_TIMESTAMP; d.size = need;
        end else if (h == 8'h04) begin
            d.done = 1'b1; d.kind = KIND_TRACEON;
        end else if (h == 8'h06) begin
            need = b[1][7] ? 5'd3 : 5'd2;
            d.done = (n >= 5'd2) && (n >= need); d.kind = KIND_EXCEPTION; d.size = need;
        end else if (h == 8'h80) begin
            d.done = 1'b1; d.kind = KIND_CONTEXT;
        end else if (h == 8'h81) begin
            need = 5'd2 + {ctx_extra4(b[1]), 2'b00};
            d.done = (n >= 5'd2) && (n >= need); d.kind = KIND_CONTEXT; d.size = need;
        end else if (h == 8'h85) begin
            need = 5'd10 + {ctx_extra4(b[9]), 2'b00};
            d.done = (n >= 5'd10) && (n >= need); d.kind = KIND_ADDRLCTX;
            d.size = need; d.addr = long_addr(b); d.upd_addr = 1'b1;
        end else if (h == 8'h95) begin
            need = b[1][7] ? 5'd3 : 5'd2;
            a = {areg[63:9], b[1][6:0], 2'b00};
            if (b[1][7]) a = {a[63:17], b[2], a[8:0]};
            d.done = (n >= 5'd2) && (n >= need); d.kind = KIND_ADDRSHORT;
            d.size = need; d.addr = a; d.upd_addr = 1'b1;
        end else if (h == 8'h9D) begin
            d.done = (n >= 5'd9); d.kind = KIND_ADDRLONG; d.size = 5'd9;
            d.addr = long_addr(b); d.upd_addr = 1'b1;
        end else if ((h >= 8'hC0 && h <= 8'hD4) || (h >= 8'hE0 && h <= 8'hF4)) begin
            e = h[4:0] + 5'd3;
            bits = (25'd1 << e) - 25'd1;
            if (!h[5]) bits = bits | (25'd1 << e);
            d.done = 1'b1; d.kind = KIND_ATOMF6; d.atoms = bits[23:0];
            d.count = e + 5'd1;
        end else if ((h >= 8'hD5 && h <= 8'hD7) || h == 8'hF5) begin
            idx = {h[5], h[1:0]};
            d.done = 1'b1; d.kind = KIND_ATOMF5; d.count = 5'd5;
            unique case (idx)
                3'd5: d.atoms = 24'h1E;
                3'd1: d.atoms = 24'h00;
                3'd2: d.atoms = 24'h0A;
                3'd3: d.atoms = 24'h15;
                default: begin
                    d.kind = KIND_UNKNOWN; d.count = 5'd0;
                end
            endcase
        end else if (h >= 8'hD8 && h <= 8'hDB) begin
            d.done = 1'b1; d.kind = KIND_ATOMF2; d.atoms = {22'h0, h[1:0]};
            d.count = 5'd2;
        end else if (h >= 8'hDC && h <= 8'hDF) begin
            d.done = 1'b1; d.kind = KIND_ATOMF4; d.count = 5'd4;
            unique case (h[1:0])
                2'd0: d.atoms = 24'hE;
                2'd1: d.atoms = 24'h0;
                2'd2: d.atoms = 24'hA;
                default: d.atoms = 24'h5;
            endcase
        end else if (h == 8'hF6 || h == 8'hF7) begin
            d.done = 1'b1; d.kind = KIND_ATOMF1; d.atoms = {23'h0, h[0]};
            d.count = 5'd1;
        end else if (h >= 8'hF8) begin
            d.done = 1'b1; d.kind = KIND_ATOMF3; d.atoms = {21'h0, h[2:0]};
            d.count = 5'd3;
        end else begin
            d.done = 1'b1;
        end
        return d;
    endfunction

endpackage

/* rtl/core/tpd_datapath.sv */
// Datapath of the trace packet decoder: holding store, address register,
// packet decode and output register. Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_byte,
    input  tpd_pkg::t_cmd     i_cmd,
    output tpd_pkg::t_stat    o_stat,
    output tpd_pkg::t_out_beat o_beat
);
    import tpd_pkg::*;

    t_hold            r_hold, n_hold, w_lead;
    logic [4:0]       r_count, n_count;
    logic [63:0]      r_areg;
    t_out_beat        r_beat, n_beat;
    t_dec             w_dec, w_lead_dec;
    logic [4:0]       w_drop;

    assign w_dec = decode(r_hold, r_count, r_areg);

    // Store as it would look with the arriving byte appended.
    always_comb begin
        w_lead = r_hold;
        if (r_count < 5'(HoldDepth)) w_lead[r_count[HoldIdxW-1:0]] = i_byte;
    end
    assign w_lead_dec = decode(w_lead,
                               (r_count < 5'(HoldDepth)) ? r_count + 5'd1 : r_count,
                               r_areg);

    assign w_drop = (w_dec.size > r_count) ? r_count : w_dec.size;

    always_comb begin
        n_hold  = r_hold;
        n_count = r_count;
        n_beat  = r_beat;
        if (i_cmd.push) begin
            n_hold  = w_lead;
            if (r_count < 5'(HoldDepth)) n_count = r_count + 5'd1;
        end else if (i_cmd.flush) begin
            n_count = '0;
            n_beat  = '{KIND_INCOMPLETE, r_count, 24'h0, 5'd0, 64'h0, 1'b1};
        end else if (i_cmd.consume) begin
            // The packet's bytes leave from the front of the store.
            n_hold  = t_hold'(r_hold >> {w_drop, 3'b000});
            n_count = r_count - w_drop;
            n_beat  = '{w_dec.kind, w_dec.size, w_dec.atoms, w_dec.count,
                        w_dec.upd_addr ? w_dec.addr : 64'h0, 1'b0};
        end else if (i_cmd.mark) begin
            // The staged beat closes the run unless the shifted store holds
            // another complete packet.
            n_beat.last_of_run = !w_dec.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_areg  <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.consume && w_dec.upd_addr) r_areg <= w_dec.addr;
        end
        r_hold <= n_hold;
        r_beat <= n_beat;
    end

    assign o_stat = '{w_dec.done, w_lead_dec.done, r_count};
    assign o_beat = r_beat;

endmodule

/* rtl/core/tpd_ctrl.sv */
// Controller of the trace packet decoder: input acceptance, emission of
// decoded packets and output valid. Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd_flush,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             i_check,
    input  tpd_pkg::t_stat   i_stat,
    output tpd_pkg::t_cmd    o_cmd
);
    import tpd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_slot, w_acc;

    // The output register is free when empty or drained this cycle.
    assign w_slot = !r_out_valid || i_out_ready;
    // The cycle after a consume belongs to the staged beat, not to a new one.
    assign o_in_ready = (r_state == ST_IDLE) && !i_check && w_slot;
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_check) begin
                    // The store has shifted; its decode tells whether another
                    // packet follows in this run.
                    o_cmd.mark  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_stat.done) n_state = ST_EMIT;
                end else if (w_acc) begin
                    if (i_cmd_flush) begin
                        if (i_stat.count != 5'd0) begin
                            o_cmd.flush = 1'b1;
                            n_out_valid = 1'b1;
                        end
                    end else begin
                        o_cmd.push = 1'b1;
                        if (i_stat.lead_done) n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_slot) begin
                    o_cmd.consume = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/tpd_seq.sv */
// Run tracker for the trace packet decoder: after each emitted packet it checks
// whether the remaining held bytes decode to another complete packet.
// Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpd_pkg::t_cmd  i_cmd,
    output logic           o_check
);
    import tpd_pkg::*;

    logic r_check;

    // In the cycle after a consume the store has shifted and can be re-decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_check <= 1'b0;
        else          r_check <= i_cmd.consume;
    end

    assign o_check = r_check;

endmodule

/* rtl/core/trace_packet_decoder.sv */
// Top level of the trace packet decoder. Instantiates tpd_top_ctrl (which holds
// tpd_ctrl and tpd_seq) and tpd_datapath; depends on tpd_pkg.
//
//   channel   direction  handshake               payload
//   in        input      i_in_valid/o_in_ready   t_in_beat
//   out       output     o_out_valid/i_out_ready t_out_beat
//
// A byte that completes no packet leaves input ready for the next byte. One that
// completes a packet is accepted, consumed into the output register, then the
// shifted store is decoded, the last flag set and valid raised; no byte is taken
// meanwhile. Each further packet of a failed async replay repeats the consume and
// decode, up to 12 results. Reset clears the held count, the address and valid.
// Emission and flushes wait while the output register holds an untaken beat.
`timescale 1ns / 1ps

module trace_packet_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tpd_pkg::t_in_beat     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tpd_pkg::t_out_beat    o_out_data
);
    import tpd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    tpd_top_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd_flush (i_in_data.cmd == CMD_FLUSH),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tpd_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_in_data.data_byte),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_beat  (o_out_data)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.push, w_cmd.flush, w_cmd.consume, w_cmd.mark}))
        else $error("overlapping datapath commands");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= 5'(HoldDepth)) else $error("held count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("beat lost");
    a_consume_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.consume |-> w_stat.done) else $error("consume of partial packet");

endmodule

/* rtl/core/tpd_top_ctrl.sv */
// Controller of the trace packet decoder with replay of held bytes after a
// failed async check: the emission state machine in tpd_ctrl and the run
// tracker in tpd_seq. Depends on tpd_pkg, tpd_ctrl and tpd_seq.
`timescale 1ns / 1ps

module tpd_top_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd_flush,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tpd_pkg::t_stat   i_stat,
    output tpd_pkg::t_cmd    o_cmd
);
    import tpd_pkg::*;

    logic w_check;
    t_cmd w_cmd;

    tpd_ctrl u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd_flush (i_cmd_flush),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_check     (w_check),
        .i_stat      (i_stat),
        .o_cmd       (w_cmd)
    );

    // Flags the cycle after each consume, when the shifted store is decoded.
    tpd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_check (w_check)
    );

    assign o_cmd = w_cmd;

endmodule

/* tb/trace_packet_decoder_tb.sv */
// Testbench for the trace packet decoder: drives trace bytes and flush beats,
// predicts every packet result and compares each output beat. Depends on tpd_pkg.
`timescale 1ns / 1ps

module trace_packet_decoder_tb;
    import tpd_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_data;

    trace_packet_decoder dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    // Predictor state.
    logic [7:0]  pend_bytes [HoldDepth];
    int          pend_count;
    logic [63:0] last_addr;

    t_out_beat   expected_pkts [$];
    int          errors = 0;
    int          cycles = 0;
    int          sent = 0;
    bit          no_idle;

    localparam int CycleLimit = 200000;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("%0t timeout", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] pend_long_addr();
        logic [63:0] a;
        a = {48'h0, pend_bytes[2][6:0], pend_bytes[1][6:0], 2'b00};
        for (int i = 3; i <= 8; i++) a |= {56'h0, pend_bytes[i]} << (16 + 8 * (i - 3));
        return a;
    endfunction

    function automatic int info_extra(logic [7:0] b);
        return (b[6] ? 4 : 0) + (b[7] ? 4 : 0);
    endfunction

    // Decode the front packet of the predictor store; 0 if not complete yet.
    function automatic bit front_packet(output t_out_beat p);
        logic [7:0] h;
        int n, need, e;
        logic [24:0] bits;
        logic [63:0] a;
        logic [2:0] idx;
        bit sync_ok;
        n = pend_count;
        h = pend_bytes[0];
        p = '0;
        p.packet_kind = KIND_UNKNOWN;
        p.pkt_len = 5'd1;
        if (h == 8'h00) begin
            if (n < 2) return 0;
            if (pend_bytes[1] == 8'h05) begin
                p.packet_kind = KIND_OVERFLOW; p.pkt_len = 5'd2; return 1;
            end
            if (n < 12) return 0;
            sync_ok = 1;
            for (int i = 0; i <= 10; i++) if (pend_bytes[i] != 8'h00) sync_ok = 0;
            if (pend_bytes[11] != 8'h80) sync_ok = 0;
            if (sync_ok) begin
                p.packet_kind = KIND_ASYNC; p.pkt_len = 5'd12;
            end
            return 1;
        end
        if (h == 8'h01) begin
            if (n < 2) return 0;
            p.packet_kind = KIND_TRACEINFO; p.pkt_len = 5'd2; return 1;
        end
        if (h == 8'h02 || h == 8'h03) begin
            need = h[0] ? 11 : 8;
            if (n < need) return 0;
            p.packet_kind = KIND_TIMESTAMP; p.pkt_len = 5'(need); return 1;
        end
        if (h == 8'h04) begin
            p.packet_kind = KIND_TRACEON; return 1;
        end
        if (h == 8'h06) begin
            if (n < 2) return 0;
            need = pend_bytes[1][7] ? 3 : 2;
            if (n < need) return 0;
            p.packet_kind = KIND_EXCEPTION; p.pkt_len = 5'(need); return 1;
        end
        if (h == 8'h80) begin
            p.packet_kind = KIND_CONTEXT; return 1;
        end
        if (h == 8'h81) begin
            if (n < 2) return 0;
            need = 2 + info_extra(pend_bytes[1]);
            if (n < need) return 0;
            p.packet_kind = KIND_CONTEXT; p.pkt_len = 5'(need); return 1;
        end
        if (h == 8'h85) begin
            if (n < 10) return 0;
            need = 10 + info_extra(pend_bytes[9]);
            if (n < need) return 0;
            last_addr = pend_long_addr();
            p.packet_kind = KIND_ADDRLCTX; p.pkt_len = 5'(need); p.address = last_addr;
            return 1;
        end
        if (h == 8'h95) begin
            if (n < 2) return 0;
            need = pend_bytes[1][7] ? 3 : 2;
            if (n < need) return 0;
            a = {last_addr[63:9], pend_bytes[1][6:0], 2'b00};
            if (need == 3) a[16:9] = pend_bytes[2];
            last_addr = a;
            p.packet_kind = KIND_ADDRSHORT; p.pkt_len = 5'(need); p.address = a;
            return 1;
        end
        if (h == 8'h9D) begin
            if (n < 9) return 0;
            last_addr = pend_long_addr();
            p.packet_kind = KIND_ADDRLONG; p.pkt_len = 5'd9; p.address = last_addr;
            return 1;
        end
        if ((h >= 8'hC0 && h <= 8'hD4) || (h >= 8'hE0 && h <= 8'hF4)) begin
            e = h[4:0] + 3;
            bits = (25'd1 << e) - 25'd1;
            if (!h[5]) bits |= 25'd1 << e;
            p.packet_kind = KIND_ATOMF6; p.atom_bits = bits[23:0];
            p.atom_count = 5'(e + 1);
            return 1;
        end
        if ((h >= 8'hD5 && h <= 8'hD7) || h == 8'hF5) begin
            idx = {h[5], h[1:0]};
            p.packet_kind = KIND_ATOMF5; p.atom_count = 5'd5;
            case (idx)
                3'd5: p.atom_bits = 24'h1E;
                3'd1: p.atom_bits = 24'h00;
                3'd2: p.atom_bits = 24'h0A;
                3'd3: p.atom_bits = 24'h15;
                default: begin
                    p.packet_kind = KIND_UNKNOWN; p.atom_count = 5'd0;
                end
            endcase
            return 1;
        end
        if (h >= 8'hD8 && h <= 8'hDB) begin
            p.packet_kind = KIND_ATOMF2; p.atom_bits = {22'h0, h[1:0]};
            p.atom_count = 5'd2; return 1;
        end
        if (h >= 8'hDC && h <= 8'hDF) begin
            p.packet_kind = KIND_ATOMF4; p.atom_count = 5'd4;
            case (h[1:0])
                2'd0: p.atom_bits = 24'hE;
                2'd1: p.atom_bits = 24'h0;
                2'd2: p.atom_bits = 24'hA;
                default: p.atom_bits = 24'h5;
            endcase
            return 1;
        end
        if (h == 8'hF6 || h == 8'hF7) begin
            p.packet_kind = KIND_ATOMF1; p.atom_bits = {23'h0, h[0]};
            p.atom_count = 5'd1; return 1;
        end
        if (h >= 8'hF8) begin
            p.packet_kind = KIND_ATOMF3; p.atom_bits = {21'h0, h[2:0]};
            p.atom_count = 5'd3; return 1;
        end
        return 1;
    endfunction

    // Advance the predictor by one input beat and queue its packets.
    task automatic predict_packets(t_in_beat b);
        t_out_beat p;
        t_out_beat run [$];
        int sz;
        if (b.cmd == CMD_FLUSH) begin
            if (pend_count > 0) begin
                p = '0;
                p.packet_kind = KIND_INCOMPLETE;
                p.pkt_len = 5'(pend_count);
                run.push_back(p);
                pend_count = 0;
            end
        end else begin
            if (pend_count < HoldDepth) begin
                pend_bytes[pend_count] = b.data_byte;
                pend_count++;
            end
            while (pend_count > 0 && run.size() < 12) begin
                if (!front_packet(p)) break;
                run.push_back(p);
                sz = p.pkt_len;
                if (sz > pend_count) sz = pend_count;
                for (int i = 0; i + sz < pend_count; i++) pend_bytes[i] = pend_bytes[i + sz];
                pend_count -= sz;
            end
        end
        if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i]) expected_pkts.push_back(run[i]);
    endtask

    task automatic send_beat(logic cmd, logic [7:0] data);
        t_in_beat b;
        b.cmd = cmd;
        b.data_byte = data;
        while (!no_idle && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_packets(b);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] d);
        send_beat(CMD_BYTE, d);
    endtask

    task automatic send_flush();
        send_beat(CMD_FLUSH, 8'($urandom_range(255)));
    endtask

    // Random receiver stall, applied on the falling edge.
    always @(negedge clk) begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);
    end

    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_pkts.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h", $time, out_data);
                errors++;
            end else begin
                want = expected_pkts.pop_front();
                if (out_data.packet_kind !== want.packet_kind ||
                    out_data.pkt_len !== want.pkt_len ||
                    out_data.atom_bits !== want.atom_bits ||
                    out_data.atom_count !== want.atom_count ||
                    out_data.address !== want.address ||
                    out_data.last_of_run !== want.last_of_run) begin
                    $display("%0t mismatch: expected %h, actual %h", $time, want, out_data);
                    errors++;
                end
            end
        end
    end

    task automatic test_headers();
        // Every single-byte packet, unassigned headers and atom extremes.
        logic [7:0] singles [] = '{8'h04, 8'h80, 8'h05, 8'h07, 8'h7F, 8'hC0, 8'hD4,
                                   8'hE0, 8'hF4, 8'hD5, 8'hD6, 8'hD7, 8'hF5, 8'hD8,
                                   8'hDB, 8'hDC, 8'hDF, 8'hF6, 8'hF7, 8'hF8, 8'hFF};
        foreach (singles[i]) send_byte(singles[i]);
    endtask

    task automatic test_multibyte();
        send_byte(8'h00); send_byte(8'h05);
        for (int i = 0; i < 11; i++) send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01); send_byte(8'hFF);
        send_byte(8'h06); send_byte(8'h80); send_byte(8'h12);
        send_byte(8'h9D);
        for (int i = 0; i < 8; i++) send_byte(8'hFF);
        send_byte(8'h95); send_byte(8'hFF); send_byte(8'hAA);
        send_byte(8'h85);
        for (int i = 0; i < 8; i++) send_byte(8'h5A);
        send_byte(8'hC0);
        for (int i = 0; i < 8; i++) send_byte(8'h33);
    endtask

    task automatic test_failed_sync();
        // Zero header, then a run that packs eleven short packets behind it.
        send_byte(8'h00);
        for (int i = 0; i < 11; i++) send_byte(8'h04);
        send_byte(8'h03);
        send_flush();
        send_flush();
    endtask

    task automatic send_random_packet();
        logic [7:0] hdrs [] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h06, 8'h81, 8'h85,
                                8'h95, 8'h9D};
        logic [7:0] h;
        logic [7:0] b;
        int len;
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) begin
            send_byte(8'($urandom_range(255)));
        end else if (sel < 15) begin
            send_flush();
        end else if (sel < 20) begin
            send_byte(8'h00);
            for (int i = 0; i < 10; i++) send_byte($urandom_range(3) == 0 ? 8'h04 : 8'h00);
            send_byte($urandom_range(1) ? 8'h80 : 8'($urandom_range(255)));
        end else if (sel < 60) begin
            send_byte(8'hC0 | 8'($urandom_range(63)));
        end else begin
            h = hdrs[$urandom_range(hdrs.size() - 1)];
            send_byte(h);
            len = 1 + $urandom_range(17);
            for (int i = 0; i < len && pend_count > 0 && pend_bytes[0] == h; i++) begin
                b = 8'($urandom_range(255));
                send_byte(b);
            end
        end
    endtask

    task automatic test_random();
        while (sent < 310) begin
            no_idle = (sent >= 150 && sent < 230);
            send_random_packet();
        end
        no_idle = 0;
        send_flush();
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        no_idle = 0;
        pend_count = 0;
        last_addr = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_headers();
        test_multibyte();
        test_failed_sync();
        test_random();
        in_valid <= 1'b0;
        while (expected_pkts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_pkts.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* trace_packet_decoder.f */
rtl/core/tpd_pkg.sv
rtl/core/tpd_datapath.sv
rtl/core/tpd_ctrl.sv
rtl/core/tpd_seq.sv
rtl/core/trace_packet_decoder.sv
rtl/core/tpd_top_ctrl.sv
tb/trace_packet_decoder_tb.sv
